/* sv/fjsp_schedule_evaluator_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the schedule evaluator RTL.
// ---------------------------------------------------------------------------
`ifndef FJSP_SCHEDULE_EVALUATOR_ASSERT_SVH
`define FJSP_SCHEDULE_EVALUATOR_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define FJSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define FJSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fjsp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fjsp_pkg
// Field widths, saturation limits and the queue entry type of the evaluator.
// ---------------------------------------------------------------------------
package fjsp_pkg;

  localparam int JOB_W   = 4;
  localparam int OP_W    = 3;
  localparam int MACH_W  = 4;
  localparam int DUR_W   = 16;
  localparam int SPAN_W  = 24;
  localparam int LOAD_W  = 28;
  localparam int ADDR_W  = 22;

  localparam logic [SPAN_W-1:0] MAKESPAN_MAX = '1;
  localparam logic [LOAD_W-1:0] LOAD_MAX     = '1;

  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_GENE  = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic              is_gene;
    logic              live;
    logic              last;
    logic [JOB_W-1:0]  job_id;
    logic [MACH_W-1:0] machine_id;
    logic [ADDR_W-1:0] addr;
    logic [DUR_W-1:0]  duration;
  } entry_t;

endpackage

/* sv/fjsp_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fjsp_item_if / fjsp_result_if
// Valid/ready channels for input items and for chromosome scores.
// ---------------------------------------------------------------------------
interface fjsp_item_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [fjsp_pkg::JOB_W-1:0]  job_id;
  logic [fjsp_pkg::OP_W-1:0]   op_index;
  logic [fjsp_pkg::MACH_W-1:0] machine_id;
  logic [fjsp_pkg::DUR_W-1:0]  duration;
  logic                       last_gene;

  modport source (output valid, opcode, job_id, op_index, machine_id, duration,
                  last_gene, input ready);
  modport sink (input valid, opcode, job_id, op_index, machine_id, duration,
                last_gene, output ready);
endinterface

interface fjsp_result_if;
  logic                       valid;
  logic                       ready;
  logic [fjsp_pkg::SPAN_W-1:0] makespan;
  logic [fjsp_pkg::LOAD_W-1:0] total_load;
  logic                       status;
  logic                       last;

  modport source (output valid, makespan, total_load, status, last, input ready);
  modport sink (input valid, makespan, total_load, status, last, output ready);
endinterface

/* sv/fjsp_schedule_evaluator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fjsp_schedule_evaluator
// Decodes flexible job shop chromosomes and scores makespan and total load.
// ---------------------------------------------------------------------------
// The item channel carries table writes and genes; the result channel gives
// one score transaction for each gene marked as the last of a chromosome.
// Table writes fill the duration table by job, operation and machine; the
// table is not cleared by reset and must be written before it is read.
// One item is accepted per cycle while the queue is not full. A gene is
// classified by the front end, passes a four-entry queue, reads the table in
// the next stage, updates the job and machine ready times in stage s1, and is
// folded into the running makespan and load in stage s2. The score of a
// chromosome is then held in the output register for the result channel.
// Reset clears the operation counters, ready times, running scores and all
// valid flags.
// When the receiver stalls, the score stays registered and the back end
// holds; the queue then fills and the item channel drops ready once four
// entries wait in the queue.
// ---------------------------------------------------------------------------
module fjsp_schedule_evaluator #(
  parameter int JOBS        = 16,
  parameter int MACHINES    = 16,
  parameter int OPS_PER_JOB = 8,
  parameter int TIME_BITS   = 24
) (
  input  logic          clk,
  input  logic          rst,
  fjsp_item_if.sink     item,
  fjsp_result_if.source result
);
  import fjsp_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  entry_t q_in;
  entry_t q_out;

  fjsp_front #(
    .JOBS        (JOBS),
    .MACHINES    (MACHINES),
    .OPS_PER_JOB (OPS_PER_JOB)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  fjsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_entry  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_entry  (q_out)
  );

  fjsp_back #(
    .JOBS        (JOBS),
    .MACHINES    (MACHINES),
    .OPS_PER_JOB (OPS_PER_JOB),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_out),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

/* sv/fjsp_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fjsp_queue
// Short FIFO of classified entries between the front and the back end.
// ---------------------------------------------------------------------------
module fjsp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fjsp_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output fjsp_pkg::entry_t rd_entry
);
  import fjsp_pkg::*;

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/fjsp_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fjsp_front
// Accepts items, checks ranges, numbers each job's operations and builds the
// duration table address for the back end.
// ---------------------------------------------------------------------------
module fjsp_front #(
  parameter int JOBS        = 16,
  parameter int MACHINES    = 16,
  parameter int OPS_PER_JOB = 8
) (
  input  logic             clk,
  input  logic             rst,
  fjsp_item_if.sink        item,
  input  logic             q_full,
  output logic             q_push,
  output fjsp_pkg::entry_t q_entry
);
  import fjsp_pkg::*;

  localparam int JW  = $clog2(JOBS);
  localparam int MW  = $clog2(MACHINES);
  localparam int OCW = $clog2(OPS_PER_JOB + 1);

  logic [OCW-1:0] op_counter [JOBS];
  logic [JW-1:0]  jidx;
  logic [MW-1:0]  midx;
  logic [OCW-1:0] cnt;
  logic           job_ok;
  logic           mach_ok;
  logic           op_ok;
  logic           cnt_ok;
  logic           is_gene;
  logic           live;
  logic [31:0]    op_sel;

  assign jidx    = JW'(item.job_id);
  assign midx    = MW'(item.machine_id);
  assign cnt     = op_counter[jidx];
  assign job_ok  = 32'(item.job_id) < 32'(JOBS);
  assign mach_ok = 32'(item.machine_id) < 32'(MACHINES);
  assign op_ok   = 32'(item.op_index) < 32'(OPS_PER_JOB);
  assign cnt_ok  = 32'(cnt) < 32'(OPS_PER_JOB);
  assign is_gene = (item.opcode == OPC_GENE);
  assign live    = job_ok && mach_ok && (is_gene ? cnt_ok : op_ok);
  assign op_sel  = is_gene ? 32'(cnt) : 32'(item.op_index);

  assign item.ready = !q_full;
  assign q_push     = item.valid && !q_full;

  always_comb begin
    q_entry.is_gene    = is_gene;
    q_entry.live       = live;
    q_entry.last       = is_gene && item.last_gene;
    q_entry.job_id     = item.job_id;
    q_entry.machine_id = item.machine_id;
    q_entry.addr       = ADDR_W'((32'(jidx) * OPS_PER_JOB + op_sel) * MACHINES + 32'(midx));
    q_entry.duration   = item.duration;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOBS; j++) begin
        op_counter[j] <= '0;
      end
    end else if (q_push && is_gene) begin
      if (item.last_gene) begin
        for (int j = 0; j < JOBS; j++) begin
          op_counter[j] <= '0;
        end
      end else if (live) begin
        op_counter[jidx] <= cnt + 1'b1;
      end
    end
  end

endmodule

/* sv/fjsp_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fjsp_back
// Duration table, finish time update and chromosome scoring with an output
// register that holds the score until it is taken.
// ---------------------------------------------------------------------------
`include "fjsp_schedule_evaluator_assert.svh"

module fjsp_back #(
  parameter int JOBS        = 16,
  parameter int MACHINES    = 16,
  parameter int OPS_PER_JOB = 8,
  parameter int TIME_BITS   = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  fjsp_pkg::entry_t q_entry,
  output logic             q_pop,
  fjsp_result_if.source    result
);
  import fjsp_pkg::*;

  localparam int JW       = $clog2(JOBS);
  localparam int MW       = $clog2(MACHINES);
  localparam int TW       = TIME_BITS;
  localparam int SUM_BITS = TIME_BITS + $clog2(MACHINES);
  localparam int TBL_DEPTH = JOBS * OPS_PER_JOB * MACHINES;
  localparam int TBL_AW   = $clog2(TBL_DEPTH);

  logic [DUR_W-1:0]    table_mem [TBL_DEPTH];
  logic [TW-1:0]       job_ready [JOBS];
  logic [TW-1:0]       machine_ready [MACHINES];

  logic                adv;
  logic                out_valid;

  logic                s1_valid;
  entry_t              s1;
  logic [DUR_W-1:0]    rdata;

  logic [JW-1:0]       s1_job;
  logic [MW-1:0]       s1_mach;
  logic [TW-1:0]       jr;
  logic [TW-1:0]       mr;
  logic [TW-1:0]       start;
  logic [TW:0]         raw;
  logic                sat;
  logic [TW-1:0]       fin;

  logic                s2_valid;
  logic                s2_last;
  logic                s2_err;
  logic [TW-1:0]       s2_fin;
  logic [TW-1:0]       s2_delta;

  logic [TW-1:0]       running_max;
  logic [SUM_BITS-1:0] running_sum;
  logic                error_seen;
  logic [TW-1:0]       max_next;
  logic [SUM_BITS-1:0] sum_next;
  logic                err_next;
  logic                span_sat;
  logic                load_sat;

  assign adv   = !out_valid || result.ready;
  assign q_pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_valid && !q_entry.is_gene && q_entry.live) begin
        table_mem[TBL_AW'(q_entry.addr)] <= q_entry.duration;
      end
      rdata <= table_mem[TBL_AW'(q_entry.addr)];
      s1    <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= q_valid;
    end
  end

  assign s1_job  = JW'(s1.job_id);
  assign s1_mach = MW'(s1.machine_id);
  assign jr      = job_ready[s1_job];
  assign mr      = machine_ready[s1_mach];
  assign start   = (jr > mr) ? jr : mr;
  assign raw     = {1'b0, start} + (TW + 1)'(rdata);
  assign sat     = raw[TW];
  assign fin     = sat ? '1 : raw[TW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOBS; j++) begin
        job_ready[j] <= '0;
      end
      for (int m = 0; m < MACHINES; m++) begin
        machine_ready[m] <= '0;
      end
    end else if (adv && s1_valid && s1.is_gene) begin
      if (s1.last) begin
        for (int j = 0; j < JOBS; j++) begin
          job_ready[j] <= '0;
        end
        for (int m = 0; m < MACHINES; m++) begin
          machine_ready[m] <= '0;
        end
      end else if (s1.live) begin
        job_ready[s1_job]      <= fin;
        machine_ready[s1_mach] <= fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last  <= s1.last;
      s2_err   <= !s1.live || sat;
      s2_fin   <= s1.live ? fin : '0;
      s2_delta <= s1.live ? (fin - mr) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1.is_gene;
    end
  end

  assign max_next = (s2_fin > running_max) ? s2_fin : running_max;
  assign sum_next = running_sum + SUM_BITS'(s2_delta);
  assign err_next = error_seen || s2_err;
  assign span_sat = 64'(max_next) > 64'(MAKESPAN_MAX);
  assign load_sat = 64'(sum_next) > 64'(LOAD_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
      running_sum <= '0;
      error_seen  <= 1'b0;
    end else if (adv && s2_valid) begin
      if (s2_last) begin
        running_max <= '0;
        running_sum <= '0;
        error_seen  <= 1'b0;
      end else begin
        running_max <= max_next;
        running_sum <= sum_next;
        error_seen  <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_last) begin
      result.makespan   <= span_sat ? MAKESPAN_MAX : SPAN_W'(max_next);
      result.total_load <= load_sat ? LOAD_MAX : LOAD_W'(sum_next);
      result.status     <= err_next || span_sat || load_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s2_valid && s2_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid = out_valid;
  assign result.last  = 1'b1;

  `FJSP_ASSERT_NEXT(a_score_on_last, adv && s2_valid && s2_last, out_valid,
                    "last gene did not produce a score")
  `FJSP_ASSERT_NEXT(a_clear_after_last, adv && s2_valid && s2_last,
                    running_max == '0 && running_sum == '0 && !error_seen,
                    "chromosome state not cleared after last gene")
  `FJSP_ASSERT_NOW(a_sum_covers_max, 1'b1, running_sum >= SUM_BITS'(running_max),
                   "total load fell below the makespan")

endmodule

/* tb/tb_fjsp_schedule_evaluator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_fjsp_schedule_evaluator
// Self-checking testbench for the flexible job shop schedule evaluator. A
// short table of directed items covers the field extremes, a table write that
// carries the last-gene flag, and operation overflow. Random chromosomes
// follow, each gene preceded by any table write it needs, mixed with random
// writes. Every accepted item runs through a local schedule scorer and each
// score transaction is checked field by field, in order, under random idling
// on both channels outside a calm stretch of chromosomes.
// ---------------------------------------------------------------------------
module tb_fjsp_schedule_evaluator;
  import fjsp_pkg::*;

  localparam int JOBS      = 16;
  localparam int MACHINES  = 16;
  localparam int OPS       = 8;
  localparam int TIME_BITS = 24;
  localparam logic [TIME_BITS:0] TIME_MAX = (25'd1 << TIME_BITS) - 25'd1;
  localparam int ITEMS     = 1700;
  localparam int IDLE_PCT  = 31;
  localparam int LIMIT_NS  = 2000000;

  typedef struct packed {
    logic              opcode;
    logic [JOB_W-1:0]  job_id;
    logic [OP_W-1:0]   op_index;
    logic [MACH_W-1:0] machine_id;
    logic [DUR_W-1:0]  duration;
    logic              last_gene;
  } item_t;

  typedef struct packed {
    logic [SPAN_W-1:0] makespan;
    logic [LOAD_W-1:0] total_load;
    logic              status;
    logic              last;
  } score_t;

  typedef struct packed {
    item_t  it;
    logic   typed;
    score_t want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [22] = '{
    '{'{OPC_WRITE, 4'd0, 3'd0, 4'd0, 16'd0, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_GENE, 4'd0, 3'd0, 4'd0, 16'd0, 1'b1}, 1'b1, '{24'd0, 28'd0, 1'b0, 1'b1}},
    '{'{OPC_WRITE, 4'd15, 3'd0, 4'd15, 16'hFFFF, 1'b1}, 1'b0,
      '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_GENE, 4'd15, 3'd7, 4'd15, 16'hFFFF, 1'b1}, 1'b1,
      '{24'd65535, 28'd65535, 1'b0, 1'b1}},
    '{'{OPC_WRITE, 4'd3, 3'd0, 4'd5, 16'd1, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_WRITE, 4'd3, 3'd1, 4'd5, 16'd1, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_WRITE, 4'd3, 3'd2, 4'd5, 16'd1, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_WRITE, 4'd3, 3'd3, 4'd5, 16'd1, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_WRITE, 4'd3, 3'd4, 4'd5, 16'd1, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_WRITE, 4'd3, 3'd5, 4'd5, 16'd1, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_WRITE, 4'd3, 3'd6, 4'd5, 16'd1, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_WRITE, 4'd3, 3'd7, 4'd5, 16'd1, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_GENE, 4'd3, 3'd0, 4'd5, 16'd0, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_GENE, 4'd3, 3'd7, 4'd5, 16'hFFFF, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_GENE, 4'd3, 3'd0, 4'd5, 16'd0, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_GENE, 4'd3, 3'd0, 4'd5, 16'd0, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_GENE, 4'd3, 3'd0, 4'd5, 16'd0, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_GENE, 4'd3, 3'd0, 4'd5, 16'd0, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_GENE, 4'd3, 3'd0, 4'd5, 16'd0, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_GENE, 4'd3, 3'd0, 4'd5, 16'd0, 1'b0}, 1'b0, '{24'd0, 28'd0, 1'b0, 1'b0}},
    '{'{OPC_GENE, 4'd3, 3'd0, 4'd5, 16'd0, 1'b1}, 1'b1, '{24'd8, 28'd8, 1'b1, 1'b1}},
    '{'{OPC_GENE, 4'd0, 3'd0, 4'd0, 16'd0, 1'b1}, 1'b1, '{24'd0, 28'd0, 1'b0, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst;
  logic score_ready = 1'b0;

  fjsp_item_if   item_bus ();
  fjsp_result_if score_bus ();

  assign score_bus.ready = score_ready;

  fjsp_schedule_evaluator u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (score_bus)
  );

  always #2 clk = ~clk;

  logic [DUR_W-1:0]     dur_tbl  [JOBS][OPS][MACHINES];
  bit                   tbl_set  [JOBS][OPS][MACHINES];
  logic [TIME_BITS-1:0] job_rdy  [JOBS];
  logic [TIME_BITS-1:0] mach_rdy [MACHINES];
  logic [3:0]           op_cnt   [JOBS];
  logic [TIME_BITS-1:0] span_acc;
  logic [LOAD_W:0]      load_acc;
  bit                   err_seen;

  score_t score_q [$];
  int     n_err  = 0;
  int     n_sent = 0;
  bit     calm   = 1'b0;

  function automatic void clear_schedule();
    for (int k = 0; k < JOBS; k++) begin
      job_rdy[k] = '0;
      op_cnt[k]  = '0;
    end
    for (int k = 0; k < MACHINES; k++) begin
      mach_rdy[k] = '0;
    end
    span_acc = '0;
    load_acc = '0;
    err_seen = 1'b0;
  endfunction

  task automatic score_item(input item_t it, output bit emits, output score_t sc);
    logic [OP_W-1:0]      op;
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS:0]   fin;
    emits = 1'b0;
    sc    = '0;
    if (it.opcode == OPC_WRITE) begin
      dur_tbl[it.job_id][it.op_index][it.machine_id] = it.duration;
      tbl_set[it.job_id][it.op_index][it.machine_id] = 1'b1;
      return;
    end
    if (op_cnt[it.job_id] >= OPS) begin
      err_seen = 1'b1;
    end else begin
      op = op_cnt[it.job_id][OP_W-1:0];
      op_cnt[it.job_id] = op_cnt[it.job_id] + 4'd1;
      start = (job_rdy[it.job_id] > mach_rdy[it.machine_id]) ?
              job_rdy[it.job_id] : mach_rdy[it.machine_id];
      fin = {1'b0, start} + dur_tbl[it.job_id][op][it.machine_id];
      if (fin > TIME_MAX) begin
        fin = TIME_MAX;
        err_seen = 1'b1;
      end
      load_acc = load_acc + fin - mach_rdy[it.machine_id];
      mach_rdy[it.machine_id] = fin[TIME_BITS-1:0];
      job_rdy[it.job_id]      = fin[TIME_BITS-1:0];
      if (fin[TIME_BITS-1:0] > span_acc) span_acc = fin[TIME_BITS-1:0];
    end
    if (!it.last_gene) return;
    emits         = 1'b1;
    sc.makespan   = span_acc;
    sc.status     = err_seen;
    sc.last       = 1'b1;
    if (load_acc > LOAD_MAX) begin
      sc.total_load = LOAD_MAX;
      sc.status     = 1'b1;
    end else begin
      sc.total_load = load_acc[LOAD_W-1:0];
    end
    clear_schedule();
  endtask

  task automatic send_item(input item_t it, input logic typed, input score_t want);
    bit     emits;
    score_t sc;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        item_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_bus.valid      <= 1'b1;
    item_bus.opcode     <= it.opcode;
    item_bus.job_id     <= it.job_id;
    item_bus.op_index   <= it.op_index;
    item_bus.machine_id <= it.machine_id;
    item_bus.duration   <= it.duration;
    item_bus.last_gene  <= it.last_gene;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    score_item(it, emits, sc);
    if (emits) score_q.insert(score_q.size(), typed ? want : sc);
    n_sent++;
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 55) return DUR_W'($urandom_range(15));
    if (r < 65) return '1;
    if (r < 70) return '0;
    return DUR_W'($urandom_range(65535));
  endfunction

  always @(posedge clk) begin : score_check
    score_t want;
    if (rst) begin
      score_ready <= 1'b0;
    end else begin
      score_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
    if (!rst && score_bus.valid && score_ready) begin
      if (score_q.size() == 0) begin
        n_err++;
        $error("score transaction with no score expected");
      end else begin
        want = score_q.pop_front();
        if (score_bus.makespan !== want.makespan) begin
          n_err++;
          $error("makespan: expected %0d, got %0d", want.makespan, score_bus.makespan);
        end
        if (score_bus.total_load !== want.total_load) begin
          n_err++;
          $error("total_load: expected %0d, got %0d", want.total_load,
                 score_bus.total_load);
        end
        if (score_bus.status !== want.status) begin
          n_err++;
          $error("status: expected %0d, got %0d", want.status, score_bus.status);
        end
        if (score_bus.last !== want.last) begin
          n_err++;
          $error("last: expected %0d, got %0d", want.last, score_bus.last);
        end
      end
    end
  end

  initial begin
    int     chrom;
    int     n_genes;
    int     n_jobs;
    int     j_base;
    int     m_base;
    int     m_cnt;
    int     job;
    int     mach;
    item_t  it;
    rst                 <= 1'b1;
    item_bus.valid      <= 1'b0;
    item_bus.opcode     <= OPC_WRITE;
    item_bus.job_id     <= '0;
    item_bus.op_index   <= '0;
    item_bus.machine_id <= '0;
    item_bus.duration   <= '0;
    item_bus.last_gene  <= 1'b0;
    clear_schedule();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].want);
    end

    chrom = 0;
    while (n_sent < ITEMS) begin
      chrom++;
      calm = (chrom >= 20 && chrom < 26);
      if (chrom % 9 == 0) begin
        item_bus.valid <= 1'b0;
        do @(posedge clk); while (score_q.size() != 0);
      end
      n_jobs  = ($urandom_range(99) < 70) ? $urandom_range(4, 1) : $urandom_range(16, 5);
      n_genes = ($urandom_range(99) < 85) ? $urandom_range(20, 1) : $urandom_range(130, 21);
      j_base  = $urandom_range(JOBS - 1);
      m_base  = $urandom_range(MACHINES - 1);
      m_cnt   = $urandom_range(MACHINES, 1);
      for (int g = 0; g < n_genes; g++) begin
        if ($urandom_range(99) < 12) begin
          it = item_t'($urandom());
          it.opcode   = OPC_WRITE;
          it.duration = pick_duration();
          send_item(it, 1'b0, '0);
        end
        job  = (j_base + $urandom_range(n_jobs - 1)) % JOBS;
        mach = (m_base + $urandom_range(m_cnt - 1)) % MACHINES;
        if (op_cnt[job] >= OPS && $urandom_range(99) < 85) begin
          for (int k = 1; k < JOBS; k++) begin
            if (op_cnt[(job + k) % JOBS] < OPS) begin
              job = (job + k) % JOBS;
              break;
            end
          end
        end
        if (op_cnt[job] < OPS && !tbl_set[job][op_cnt[job][OP_W-1:0]][mach]) begin
          it.opcode     = OPC_WRITE;
          it.job_id     = JOB_W'(job);
          it.op_index   = op_cnt[job][OP_W-1:0];
          it.machine_id = MACH_W'(mach);
          it.duration   = pick_duration();
          it.last_gene  = 1'($urandom_range(1));
          send_item(it, 1'b0, '0);
        end
        it.opcode     = OPC_GENE;
        it.job_id     = JOB_W'(job);
        it.op_index   = OP_W'($urandom_range(OPS - 1));
        it.machine_id = MACH_W'(mach);
        it.duration   = DUR_W'($urandom_range(65535));
        it.last_gene  = (g == n_genes - 1);
        send_item(it, 1'b0, '0);
      end
    end

    item_bus.valid <= 1'b0;
    calm = 1'b0;
    while (score_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (n_err == 0 && score_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* fjsp_schedule_evaluator.f */
+incdir+sv
sv/fjsp_pkg.sv
sv/fjsp_if.sv
sv/fjsp_queue.sv
sv/fjsp_front.sv
sv/fjsp_back.sv
sv/fjsp_schedule_evaluator.sv
tb/tb_fjsp_schedule_evaluator.sv
